/* rtl/mbnc_pkg.sv */
// Shared types and constants for the minimum-radix numeral converter.
`default_nettype none

package mbnc_pkg;

    // Widths and counts
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int NUM_BASES       = 36;
    localparam int CHAR_W          = 8;
    localparam int DIGIT_W         = 6;
    localparam int BASE_W          = 6;
    localparam int OUT_VALUE_W     = 32;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO     = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE     = 8'd57;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A  = 8'd65;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z  = 8'd90;
    localparam logic [CHAR_W-1:0] LETTER_OFFSET = 8'd55;
    localparam logic [CHAR_W-1:0] CHAR_SPACE    = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TAB      = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_VTAB     = 8'h0B;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE  = 8'h0A;

    // Classified input byte
    typedef struct packed {
        logic               is_sep;
        logic [DIGIT_W-1:0] digit;
    } t_char_info;

    // Per-lane accumulator control
    typedef struct packed {
        logic step;
        logic clear;
    } t_lane_ctrl;

endpackage

`default_nettype wire

/* rtl/mbnc_decode.sv */
// Byte classifier: separator detect and digit value.
`default_nettype none

module mbnc_decode (
    input  wire logic [mbnc_pkg::CHAR_W-1:0] i_char,
    output mbnc_pkg::t_char_info             o_info
);

    logic [mbnc_pkg::CHAR_W-1:0] w_diff;

    // Separator set and digit value; anything else is a zero digit
    always_comb begin
        w_diff        = '0;
        o_info.is_sep = (i_char inside {mbnc_pkg::CHAR_SPACE, mbnc_pkg::CHAR_TAB,
                                        mbnc_pkg::CHAR_VTAB, mbnc_pkg::CHAR_NEWLINE});
        if (i_char inside {[mbnc_pkg::CHAR_ZERO:mbnc_pkg::CHAR_NINE]}) begin
            w_diff = i_char - mbnc_pkg::CHAR_ZERO;
        end else if (i_char inside {[mbnc_pkg::CHAR_UPPER_A:mbnc_pkg::CHAR_UPPER_Z]}) begin
            w_diff = i_char - mbnc_pkg::LETTER_OFFSET;
        end
        o_info.digit = w_diff[mbnc_pkg::DIGIT_W-1:0];
    end

endmodule

`default_nettype wire

/* rtl/mbnc_lane.sv */
// One Horner accumulator for a fixed radix.
`default_nettype none

module mbnc_lane #(
    parameter int VALUE_WIDTH = mbnc_pkg::VALUE_WIDTH_DEF,
    parameter int RADIX       = 1
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire mbnc_pkg::t_lane_ctrl         i_ctrl,
    input  wire logic [mbnc_pkg::DIGIT_W-1:0] i_digit,
    output logic [VALUE_WIDTH-1:0]            o_acc
);

    logic [VALUE_WIDTH-1:0] r_acc;
    logic [VALUE_WIDTH-1:0] n_acc;

    // acc = acc * radix + digit on step, wrapping at VALUE_WIDTH; clear zeroes it
    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.clear) begin
            n_acc = '0;
        end else if (i_ctrl.step) begin
            n_acc = r_acc * VALUE_WIDTH'(RADIX) + VALUE_WIDTH'(i_digit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

/* rtl/min_base_numeral_converter_core.sv */
// Top level: minimum-radix detection and radix conversion of a byte stream.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------
//   input   | in        | i_valid / o_ready  | i_char_in[7:0]
//   result  | out       | o_valid / i_ready  | o_base[5:0], o_value[31:0]
//
// One byte per cycle sustained, but a separator that closes a token waits
// in the input register only while the result register holds an untaken
// result. A byte sits in the input register, where the 36 per-radix lanes
// (one constant multiply-add each) and the token tracker update; a closing
// separator loads the result register. Reset (synchronous, low) clears
// all lanes, the token state and both valid flags.
`default_nettype none

module min_base_numeral_converter_core #(
    parameter int VALUE_WIDTH = mbnc_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic [mbnc_pkg::CHAR_W-1:0]      i_char_in,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic [mbnc_pkg::BASE_W-1:0]           o_base,
    output logic [mbnc_pkg::OUT_VALUE_W-1:0]      o_value
);

    // Input register
    logic                        r_in_valid;
    logic [mbnc_pkg::CHAR_W-1:0] r_char;

    // Token state
    logic                         r_in_token;
    logic [mbnc_pkg::DIGIT_W-1:0] r_max_digit;

    // Result register
    logic                              r_out_valid;
    logic [mbnc_pkg::BASE_W-1:0]       r_base;
    logic [mbnc_pkg::OUT_VALUE_W-1:0]  r_value;

    mbnc_pkg::t_char_info w_info;
    mbnc_pkg::t_lane_ctrl w_ctrl;
    logic                 w_out_free;
    logic                 w_emit;
    logic                 w_adv;

    logic [VALUE_WIDTH-1:0]              w_acc [mbnc_pkg::NUM_BASES];
    logic [VALUE_WIDTH-1:0]              w_sel_acc;
    logic [mbnc_pkg::OUT_VALUE_W-1:0]    w_sel_value;

    mbnc_decode u_decode (
        .i_char (r_char),
        .o_info (w_info)
    );

    // Handshake and advance control
    assign w_out_free = !r_out_valid || i_ready;
    assign w_emit     = r_in_valid && w_info.is_sep && r_in_token;
    assign w_adv      = r_in_valid && (!w_emit || w_out_free);
    assign o_ready    = !r_in_valid || w_adv;

    assign w_ctrl.step  = w_adv && !w_info.is_sep;
    assign w_ctrl.clear = w_adv && w_emit;

    // One accumulator lane per radix 1..36
    for (genvar g = 0; g < mbnc_pkg::NUM_BASES; g++) begin : g_lane
        mbnc_lane #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .RADIX       (g + 1)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_digit (w_info.digit),
            .o_acc   (w_acc[g])
        );
    end

    // Pick the lane of the minimal radix and fit it to 32 bits
    assign w_sel_acc = w_acc[r_max_digit];

    if (VALUE_WIDTH >= mbnc_pkg::OUT_VALUE_W) begin : g_trunc
        assign w_sel_value = w_sel_acc[mbnc_pkg::OUT_VALUE_W-1:0];
    end else begin : g_ext
        assign w_sel_value = {{(mbnc_pkg::OUT_VALUE_W - VALUE_WIDTH){1'b0}}, w_sel_acc};
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_char <= i_char_in;
        end
    end

    // Token tracker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_token  <= 1'b0;
            r_max_digit <= '0;
        end else if (w_adv) begin
            if (w_info.is_sep) begin
                r_in_token  <= 1'b0;
                r_max_digit <= '0;
            end else begin
                r_in_token <= 1'b1;
                if (w_info.digit > r_max_digit) begin
                    r_max_digit <= w_info.digit;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_adv && w_emit) begin
            r_base  <= mbnc_pkg::BASE_W'(r_max_digit) + mbnc_pkg::BASE_W'(1);
            r_value <= w_sel_value;
        end
    end

    assign o_valid = r_out_valid;
    assign o_base  = r_base;
    assign o_value = r_value;

    // Checks
    a_base_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_base != '0) && (o_base <= mbnc_pkg::BASE_W'(mbnc_pkg::NUM_BASES)))
        else $error("result base out of range");

    a_max_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_max_digit < mbnc_pkg::DIGIT_W'(mbnc_pkg::NUM_BASES))
        else $error("max digit out of range");

    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_emit) |=> (!r_in_token && (r_max_digit == '0) && o_valid))
        else $error("token state not cleared after result");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && !w_out_free) |=> (r_in_valid && $stable(r_char) && r_in_token))
        else $error("closing separator lost while result stalled");

endmodule

`default_nettype wire
